// ===== sv/rbp_pkg.sv =====
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types, constants and controller codes for the receive buffer
// pre-division block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbp_pkg;

  localparam int MAX_SUBFLOWS_DEF = 8;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CWND_W    = 20;
  localparam int RTT_W     = 29;
  localparam int SEQ_W     = 32;
  localparam int OCC_W     = 32;
  localparam int RATIO_W   = 30;
  localparam int DIV_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BUFFER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

  typedef struct packed {
    logic [2:0]        subflow_index;
    logic              new_subflow;
    logic [CWND_W-1:0] congestion_window;
    logic [31:0]       smoothed_rtt;
    logic [SEQ_W-1:0]  write_sequence;
    logic [SEQ_W-1:0]  unacked_sequence;
    logic              last_record;
  } rec_t;

  typedef struct packed {
    logic [2:0]       out_subflow;
    logic [CFG_W-1:0] allocated_share;
    logic [CFG_W-1:0] window_share;
    logic             last_result;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_OCC_START,
    S_OCC_WAIT,
    S_OCC_MUL,
    S_OCC_ACC,
    S_ALLOC_START,
    S_ALLOC_WAIT,
    S_WIN_START,
    S_WIN_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic round_clr;
    logic scan;
    logic cnt_inc;
    logic cnt_clr;
    logic occ_start;
    logic occ_ratio;
    logic occ_mul;
    logic occ_acc;
    logic alloc_start;
    logic alloc_done;
    logic win_start;
    logic out_load;
    logic clear_present;
  } cmd_t;

  typedef struct packed {
    logic rec_last;
    logic cnt_end;
    logic present_cur;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/rbp_div.sv =====
// ----------------------------------------------------------------------------
// rbp_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [rbp_pkg::DIV_W-1:0] dividend,
  input  wire logic [rbp_pkg::DIV_W-1:0] divisor,
  output logic                          busy,
  output logic [rbp_pkg::DIV_W-1:0]      quotient
);
  import rbp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic [DIV_W:0]   shifted;
  logic             fits;

  // shift in the next dividend bit and try the subtract
  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // advance the remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[DIV_W-1:0];
      end
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== sv/rbp_dp.sv =====
// ----------------------------------------------------------------------------
// rbp_dp
// Datapath: subflow tables, round accumulators, operand selection for the
// shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_dp #(
  parameter int MAX_SUBFLOWS = rbp_pkg::MAX_SUBFLOWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbp_pkg::CFG_W-1:0]     cfg_data,
  input  wire rbp_pkg::rec_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output rbp_pkg::res_t                     out_data,
  input  wire rbp_pkg::cmd_t                cmd,
  output rbp_pkg::sts_t                     sts
);
  import rbp_pkg::*;

  localparam int CW    = $clog2(MAX_SUBFLOWS);
  localparam int IW    = (CW > 3) ? CW : 3;
  localparam int TOT_W = OCC_W + CW;
  localparam int SUM_W = CFG_W + CW;
  localparam int PRD_W = CWND_W + RATIO_W;

  logic [CFG_W-1:0]        buf_bytes;
  logic [CFG_W-1:0]        win_bytes;
  rec_t                    rec;
  logic [CWND_W-1:0]       avg  [MAX_SUBFLOWS];
  logic [RTT_W-1:0]        rtt  [MAX_SUBFLOWS];
  logic [SEQ_W-1:0]        infl [MAX_SUBFLOWS];
  logic [OCC_W-1:0]        occ  [MAX_SUBFLOWS];
  logic [MAX_SUBFLOWS-1:0] present;
  logic [CW-1:0]           cnt;
  logic [RTT_W-1:0]        max1;
  logic [RTT_W-1:0]        max2;
  logic [CW-1:0]           idx1;
  logic [TOT_W-1:0]        total;
  logic [SUM_W-1:0]        sum;
  logic [RATIO_W-1:0]      ratio;
  logic [PRD_W-1:0]        prod;

  logic              rec_ok;
  logic [IW-1:0]     rec_ext;
  logic [CW-1:0]     rec_addr;
  logic [CW-1:0]     rd_addr;
  logic [IW-1:0]     cnt_ext;
  logic [CWND_W-1:0] avg_rd;
  logic [CWND_W-1:0] a_base;
  logic [CWND_W:0]   a_sum;
  logic [CWND_W-1:0] a_new;
  logic [SEQ_W-1:0]  seq_gap;
  logic [SEQ_W-1:0]  infl_new;
  logic [RTT_W-1:0]  rtt_cur;
  logic [RTT_W-1:0]  own;
  logic [RTT_W-1:0]  other_raw;
  logic [RTT_W-1:0]  other;
  logic [RTT_W:0]    two_own;
  logic [RTT_W+1:0]  occ_dvd;
  logic [OCC_W-1:0]  occ_sat;
  logic [CFG_W-1:0]  alloc;
  logic [SEQ_W-1:0]  rest;
  logic [TOT_W-1:0]  tot_eff;
  logic [SUM_W-1:0]  sum_eff;
  logic [62:0]       alloc_prod;
  logic [61:0]       win_prod;
  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [DIV_W-1:0]  div_dvs;
  logic              div_busy;
  logic [DIV_W-1:0]  quo;

  // decode record index and the shared read port of the averaged-window table
  assign rec_ok   = int'(rec.subflow_index) < MAX_SUBFLOWS;
  assign rec_ext  = IW'(rec.subflow_index);
  assign rec_addr = rec_ext[CW-1:0];
  assign rd_addr  = cmd.update ? rec_addr : cnt;
  assign cnt_ext  = IW'(cnt);
  assign avg_rd   = avg[rd_addr];
  assign rtt_cur  = rtt[cnt];

  // averaged window step and in-flight distance
  always_comb begin
    a_base   = rec.new_subflow ? rec.congestion_window : avg_rd;
    a_sum    = {1'b0, a_base} - {5'd0, a_base[CWND_W-1:4]}
               + {5'd0, rec.congestion_window[CWND_W-1:4]};
    a_new    = (a_sum == '0) ? CWND_W'(1) : a_sum[CWND_W-1:0];
    seq_gap  = rec.write_sequence - rec.unacked_sequence;
    infl_new = ((seq_gap != '0) && (seq_gap <= 32'h8000_0000)) ? seq_gap : '0;
  end

  // ratio operands: own and largest other RTT
  always_comb begin
    own       = (rtt_cur == '0) ? RTT_W'(1) : rtt_cur;
    other_raw = (idx1 == cnt) ? max2 : max1;
    other     = (other_raw == '0) ? own : other_raw;
    two_own   = {own, 1'b0};
    occ_dvd   = {2'b00, other} + {1'b0, two_own} - (RTT_W+2)'(1);
  end

  // saturate occupancy, clamp the round sums, split the share
  always_comb begin
    occ_sat    = (prod[PRD_W-1:OCC_W] != '0) ? '1 : prod[OCC_W-1:0];
    tot_eff    = (total == '0) ? TOT_W'(1) : total;
    sum_eff    = (sum == '0) ? SUM_W'(1) : sum;
    alloc      = quo[CFG_W-1:0];
    rest       = ({1'b0, alloc} > infl[cnt]) ? ({1'b0, alloc} - infl[cnt]) : '0;
    alloc_prod = {32'd0, buf_bytes} * {31'd0, occ[cnt]};
    win_prod   = {31'd0, win_bytes} * {31'd0, infl[cnt][CFG_W-1:0]};
  end

  // select divider operands
  always_comb begin
    div_start = cmd.occ_start | cmd.alloc_start | cmd.win_start;
    div_dvd   = DIV_W'(occ_dvd);
    div_dvs   = DIV_W'(two_own);
    if (cmd.alloc_start) begin
      div_dvd = DIV_W'(alloc_prod);
      div_dvs = DIV_W'(tot_eff);
    end else if (cmd.win_start) begin
      div_dvd = DIV_W'(win_prod);
      div_dvs = DIV_W'(sum_eff);
    end
  end

  rbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quo)
  );

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_bytes <= CFG_W'(87380);
      win_bytes <= CFG_W'(65535);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER: buf_bytes <= cfg_data;
        REG_WINDOW: win_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state: present set, counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.update && rec_ok) begin
        present[rec_addr] <= 1'b1;
      end else if (cmd.clear_present) begin
        present <= '0;
      end
      if (cmd.round_clr || cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // table writes and round accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec <= in_data;
    end
    if (cmd.update && rec_ok) begin
      avg[rec_addr]  <= a_new;
      rtt[rec_addr]  <= rec.smoothed_rtt[31:3];
      infl[rec_addr] <= infl_new;
    end
    if (cmd.round_clr) begin
      max1  <= '0;
      max2  <= '0;
      idx1  <= '0;
      total <= '0;
      sum   <= '0;
    end
    if (cmd.scan && present[cnt]) begin
      if (rtt_cur > max1) begin
        max2 <= max1;
        max1 <= rtt_cur;
        idx1 <= cnt;
      end else if (rtt_cur > max2) begin
        max2 <= rtt_cur;
      end
    end
    if (cmd.occ_ratio) begin
      ratio <= quo[RATIO_W-1:0] + RATIO_W'(1);
    end
    if (cmd.occ_mul) begin
      prod <= PRD_W'(avg_rd) * PRD_W'(ratio);
    end
    if (cmd.occ_acc) begin
      occ[cnt] <= occ_sat;
      total    <= total + TOT_W'(occ_sat);
    end
    // keep the share in the occupancy slot and what remains in the in-flight slot
    if (cmd.alloc_done) begin
      occ[cnt]  <= {1'b0, alloc};
      infl[cnt] <= rest;
      sum       <= sum + SUM_W'(rest);
    end
    if (cmd.out_load) begin
      out_data.out_subflow     <= cnt_ext[2:0];
      out_data.allocated_share <= occ[cnt][CFG_W-1:0];
      out_data.window_share    <= quo[CFG_W-1:0];
      out_data.last_result     <=
        (present >> cnt) == {{(MAX_SUBFLOWS-1){1'b0}}, 1'b1};
    end
  end

  // report status
  always_comb begin
    sts.rec_last    = rec.last_record;
    sts.cnt_end     = cnt == CW'(MAX_SUBFLOWS - 1);
    sts.present_cur = present[cnt];
    sts.div_busy    = div_busy;
    sts.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== sv/rbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbp_ctrl
// Round sequencer: record update, RTT scan, then three divider passes over
// the subflows (occupancy, buffer share, window share).
// ----------------------------------------------------------------------------
`default_nettype none

module rbp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rbp_pkg::sts_t sts,
  output rbp_pkg::cmd_t      cmd,
  output rbp_pkg::state_t    state
);
  import rbp_pkg::*;

  state_t state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = state != S_IDLE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.rec_last) begin
          cmd.round_clr = 1'b1;
          state_next    = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.cnt_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_OCC_START;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_OCC_START: begin
        if (sts.present_cur) begin
          cmd.occ_start = 1'b1;
          state_next    = S_OCC_WAIT;
        end else if (sts.cnt_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_ALLOC_START;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_OCC_WAIT: begin
        if (!sts.div_busy) begin
          cmd.occ_ratio = 1'b1;
          state_next    = S_OCC_MUL;
        end
      end
      S_OCC_MUL: begin
        cmd.occ_mul = 1'b1;
        state_next  = S_OCC_ACC;
      end
      S_OCC_ACC: begin
        cmd.occ_acc = 1'b1;
        if (sts.cnt_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_ALLOC_START;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_OCC_START;
        end
      end
      S_ALLOC_START: begin
        if (sts.present_cur) begin
          cmd.alloc_start = 1'b1;
          state_next      = S_ALLOC_WAIT;
        end else if (sts.cnt_end) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_WIN_START;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_ALLOC_WAIT: begin
        if (!sts.div_busy) begin
          cmd.alloc_done = 1'b1;
          if (sts.cnt_end) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_WIN_START;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_ALLOC_START;
          end
        end
      end
      S_WIN_START: begin
        if (sts.present_cur) begin
          cmd.win_start = 1'b1;
          state_next    = S_WIN_WAIT;
        end else if (sts.cnt_end) begin
          cmd.clear_present = 1'b1;
          state_next        = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_WIN_WAIT: begin
        // drop the result into the output register once it is free
        if (!sts.div_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.cnt_end) begin
            cmd.clear_present = 1'b1;
            state_next        = S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_WIN_START;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/receive_buffer_predivision.sv =====
// ----------------------------------------------------------------------------
// receive_buffer_predivision
// Per-round division of the receive buffer and window among subflows.
// ----------------------------------------------------------------------------
// A record without the last flag is accepted in S_IDLE and then updates the
// tables in S_UPDATE. A record with the last flag also runs the RTT scan
// over all MAX_SUBFLOWS entries, then three passes over the subflows that
// skip absent ones and, for each present one, run a division (occupancy
// ratio, buffer share, window share) on the shared one-bit-per-cycle
// divider, with a start step and a finish step; the occupancy pass also
// forms and adds the occupancy. Results come out in ascending subflow
// order, one per present subflow, and a stalled result holds the round at
// that subflow. Registers: index 0 is the buffer size, index 1 the window;
// write them only while the block is idle.
`default_nettype none

module receive_buffer_predivision #(
  parameter int MAX_SUBFLOWS = rbp_pkg::MAX_SUBFLOWS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rbp_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire rbp_pkg::rec_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output rbp_pkg::res_t                     out_data
);
  import rbp_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  rbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  rbp_dp #(
    .MAX_SUBFLOWS (MAX_SUBFLOWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // a result is loaded only from a finished division into a free register
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!sts.div_busy && sts.out_free))
    else $error("result loaded while divider busy or output full");

  // the divider is never restarted mid-division
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.occ_start || cmd.alloc_start || cmd.win_start) |-> !sts.div_busy)
    else $error("divider started while busy");

  // a started division is busy on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.occ_start || cmd.alloc_start || cmd.win_start) |=> sts.div_busy)
    else $error("divider did not start");

  // records are taken only between rounds
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE))
    else $error("record accepted during a round");
`endif

endmodule

`default_nettype wire
